// ===== hdl/button_autorepeat_scanner_macros.svh =====
// Assertion macros shared by the button autorepeat scanner
`ifndef BUTTON_AUTOREPEAT_SCANNER_MACROS_SVH
`define BUTTON_AUTOREPEAT_SCANNER_MACROS_SVH

// Same-cycle implication, checked on aclk outside reset
`define BAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset
`define BAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bas_pkg.sv =====
// Types and constants of the button autorepeat scanner
package bas_pkg;

    localparam int BTN_W      = 12;
    localparam int AXIS_W     = 8;
    localparam int DIR_W      = 4;
    localparam int MS_W       = 16;
    localparam int TPM_W      = 20;
    localparam int SPAN_PROD_W = MS_W + TPM_W;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AUTOREPEAT_MODE = 2'd0,
        CFG_INITIAL_DELAY   = 2'd1,
        CFG_REPEAT_INTERVAL = 2'd2,
        CFG_TICKS_PER_MS    = 2'd3
    } cfg_index_t;

    // Register reset values
    localparam logic [MS_W-1:0]  INITIAL_DELAY_RST   = 16'd400;
    localparam logic [MS_W-1:0]  REPEAT_INTERVAL_RST = 16'd50;
    localparam logic [TPM_W-1:0] TICKS_PER_MS_RST    = 20'd1000;

    // Stick thresholds
    localparam logic [AXIS_W-1:0] AXIS_LOW  = 8'd32;
    localparam logic [AXIS_W-1:0] AXIS_HIGH = 8'd224;

    // Direction bit positions
    localparam int DIR_UP    = 0;
    localparam int DIR_DOWN  = 1;
    localparam int DIR_LEFT  = 2;
    localparam int DIR_RIGHT = 3;

endpackage

// ===== hdl/button_autorepeat_scanner.sv =====
// A poll's report is registered in the input stage and then in the output stage.
// Throughput: one poll per cycle while the output can take a report; timer compare and reload is one stage.
// A rearm poll never stalls in the input stage and gives no result.
// Reset (aresetn low at a clock edge) restores the register defaults and idles every button.
// Timer spans are products of the registers, refreshed in the cycle after a write.
`include "button_autorepeat_scanner_macros.svh"

module button_autorepeat_scanner #(
    parameter int NUM_BUTTONS = 12,
    parameter int TICK_WIDTH  = 48
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration writes
    input  logic                            cfg_wr_en,
    input  logic [bas_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bas_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Poll samples
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_rearm,
    input  logic [bas_pkg::BTN_W-1:0]       s_raw_buttons,
    input  logic [bas_pkg::AXIS_W-1:0]      s_axis_x,
    input  logic [bas_pkg::AXIS_W-1:0]      s_axis_y,
    input  logic [TICK_WIDTH-1:0]           s_now_tick,
    // Reports
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bas_pkg::BTN_W-1:0]       m_reported_buttons,
    output logic [bas_pkg::DIR_W-1:0]       m_stick_directions,
    output logic [bas_pkg::AXIS_W-1:0]      m_stick_x_out,
    output logic [bas_pkg::AXIS_W-1:0]      m_stick_y_out
);
    import bas_pkg::*;

    localparam int EXT_W = NUM_BUTTONS + BTN_W;

    typedef struct packed {
        logic                  rearm;
        logic [BTN_W-1:0]      raw;
        logic [AXIS_W-1:0]     ax;
        logic [AXIS_W-1:0]     ay;
        logic [TICK_WIDTH-1:0] now;
    } poll_t;

    // Configuration registers
    logic              mode_reg;
    logic [MS_W-1:0]   delay_ms_reg;
    logic [MS_W-1:0]   repeat_ms_reg;
    logic [TPM_W-1:0]  tpm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            delay_ms_reg  <= INITIAL_DELAY_RST;
            repeat_ms_reg <= REPEAT_INTERVAL_RST;
            tpm_reg       <= TICKS_PER_MS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_AUTOREPEAT_MODE: mode_reg      <= cfg_wdata[0];
                CFG_INITIAL_DELAY:   delay_ms_reg  <= cfg_wdata[MS_W-1:0];
                CFG_REPEAT_INTERVAL: repeat_ms_reg <= cfg_wdata[MS_W-1:0];
                CFG_TICKS_PER_MS:    tpm_reg       <= cfg_wdata[TPM_W-1:0];
                default: ;
            endcase
        end
    end

    // Convert the millisecond settings to tick spans, wrapped to the tick width
    logic [SPAN_PROD_W-1:0]            delay_prod;
    logic [SPAN_PROD_W-1:0]            repeat_prod;
    logic [SPAN_PROD_W+TICK_WIDTH-1:0] delay_ext;
    logic [SPAN_PROD_W+TICK_WIDTH-1:0] repeat_ext;
    logic [TICK_WIDTH-1:0]             delay_span_reg;
    logic [TICK_WIDTH-1:0]             repeat_span_reg;

    assign delay_prod  = SPAN_PROD_W'(delay_ms_reg) * SPAN_PROD_W'(tpm_reg);
    assign repeat_prod = SPAN_PROD_W'(repeat_ms_reg) * SPAN_PROD_W'(tpm_reg);
    assign delay_ext   = {{TICK_WIDTH{1'b0}}, delay_prod};
    assign repeat_ext  = {{TICK_WIDTH{1'b0}}, repeat_prod};

    always_ff @(posedge aclk) begin
        delay_span_reg  <= delay_ext[TICK_WIDTH-1:0];
        repeat_span_reg <= repeat_ext[TICK_WIDTH-1:0];
    end

    // Input stage
    logic  in_vld_reg;
    poll_t in_reg;
    logic  in_adv;
    logic  m_valid_reg;

    // A rearm poll leaves without a result; a report needs room in the output stage
    assign in_adv  = in_vld_reg && (in_reg.rearm || !m_valid_reg || m_ready);
    assign s_ready = !in_vld_reg || in_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= '{rearm: s_rearm, raw: s_raw_buttons, ax: s_axis_x,
                        ay: s_axis_y, now: s_now_tick};
        end
    end

    // Per-button timers
    logic [NUM_BUTTONS-1:0] armed_reg;
    logic [NUM_BUTTONS-1:0] armed_next;
    logic [TICK_WIDTH-1:0]  timer_reg  [NUM_BUTTONS];
    logic [TICK_WIDTH-1:0]  timer_next [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] report_vec;
    logic [EXT_W-1:0]       held_ext;
    logic [EXT_W-1:0]       report_ext;

    assign held_ext   = {{NUM_BUTTONS{1'b0}}, in_reg.raw};
    assign report_ext = {{BTN_W{1'b0}}, report_vec};

    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
        logic                  held;
        logic                  due;
        logic [TICK_WIDTH-1:0] gap;
        logic [TICK_WIDTH-1:0] reload;

        assign held   = held_ext[i];
        assign due    = !armed_reg[i] || (in_reg.now >= timer_reg[i]);
        assign gap    = (in_reg.rearm || !armed_reg[i]) ? delay_span_reg : repeat_span_reg;
        assign reload = in_reg.now + gap;

        // Decide report and next timer state for this button
        always_comb begin
            armed_next[i] = armed_reg[i];
            timer_next[i] = timer_reg[i];
            report_vec[i] = 1'b0;
            if (!mode_reg) begin
                report_vec[i] = held;
            end else if (in_reg.rearm) begin
                armed_next[i] = held;
                timer_next[i] = reload;
            end else if (held) begin
                if (due) begin
                    report_vec[i] = 1'b1;
                    armed_next[i] = 1'b1;
                    timer_next[i] = reload;
                end
            end else begin
                armed_next[i] = 1'b0;
            end
        end

        always_ff @(posedge aclk) begin
            if (in_adv) begin
                timer_reg[i] <= timer_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= '0;
        end else if (in_adv) begin
            armed_reg <= armed_next;
        end
    end

    // Classify the stick axes
    logic [DIR_W-1:0] dirs;

    always_comb begin
        dirs            = '0;
        dirs[DIR_UP]    = in_reg.ay < AXIS_LOW;
        dirs[DIR_DOWN]  = in_reg.ay >= AXIS_HIGH;
        dirs[DIR_LEFT]  = in_reg.ax < AXIS_LOW;
        dirs[DIR_RIGHT] = in_reg.ax >= AXIS_HIGH;
    end

    // Output stage
    logic [BTN_W-1:0]  out_buttons_reg;
    logic [DIR_W-1:0]  out_dirs_reg;
    logic [AXIS_W-1:0] out_x_reg;
    logic [AXIS_W-1:0] out_y_reg;
    logic              out_load;

    assign out_load = in_adv && !in_reg.rearm;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_buttons_reg <= report_ext[BTN_W-1:0];
            out_dirs_reg    <= dirs;
            out_x_reg       <= in_reg.ax;
            out_y_reg       <= in_reg.ay;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_reported_buttons = out_buttons_reg;
    assign m_stick_directions = out_dirs_reg;
    assign m_stick_x_out      = out_x_reg;
    assign m_stick_y_out      = out_y_reg;

    // Checks
    `BAS_ASSERT_NOW(a_stall_only_on_full_output, in_vld_reg && !in_adv,
        !in_reg.rearm && m_valid_reg && !m_ready,
        "input stage stalled without a waiting report")
    `BAS_ASSERT_NEXT(a_report_follows_poll, out_load, m_valid_reg,
        "report lost after a poll left the input stage")
    `BAS_ASSERT_NEXT(a_report_subset_of_held, out_load,
        (m_reported_buttons & ~$past(in_reg.raw)) == '0,
        "button reported while not held")
    `BAS_ASSERT_NEXT(a_normal_mode_keeps_timers, !mode_reg && !cfg_wr_en,
        armed_reg == $past(armed_reg),
        "timer state changed in direct mode")

endmodule

// ===== sim/tb_button_autorepeat_scanner.sv =====
// Self-checking testbench for the button autorepeat scanner: poll stream in, report stream out
`timescale 1ns / 1ps

module tb_button_autorepeat_scanner;
    import bas_pkg::*;

    localparam int TICK_W        = 48;
    localparam int PHASE_POLLS   = 240;
    localparam int SETTLE_CYCLES = 8;
    localparam int STUCK_LIMIT   = 2000;
    localparam int PRESSURE_HOLD = 150;
    localparam logic [TICK_W-1:0] TICK_MAX = '1;
    localparam logic [AXIS_W-1:0] AXIS_EDGES [8] = '{
        8'd0, 8'd31, 8'd32, 8'd127, 8'd128, 8'd223, 8'd224, 8'd255
    };

    typedef struct packed {
        logic              rearm;
        logic [BTN_W-1:0]  raw;
        logic [AXIS_W-1:0] ax;
        logic [AXIS_W-1:0] ay;
        logic [TICK_W-1:0] now;
    } poll_t;

    typedef struct packed {
        logic [BTN_W-1:0]  buttons;
        logic [DIR_W-1:0]  dirs;
        logic [AXIS_W-1:0] x;
        logic [AXIS_W-1:0] y;
    } report_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    cfg_index_t            cfg_index = CFG_AUTOREPEAT_MODE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_rearm = 1'b0;
    logic [BTN_W-1:0]      s_raw_buttons = '0;
    logic [AXIS_W-1:0]     s_axis_x = '0;
    logic [AXIS_W-1:0]     s_axis_y = '0;
    logic [TICK_W-1:0]     s_now_tick = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [BTN_W-1:0]      m_reported_buttons;
    logic [DIR_W-1:0]      m_stick_directions;
    logic [AXIS_W-1:0]     m_stick_x_out;
    logic [AXIS_W-1:0]     m_stick_y_out;

    // Mirror of the configuration registers and the per-button timers
    logic              mode_cfg = 1'b0;
    logic [MS_W-1:0]   delay_cfg = INITIAL_DELAY_RST;
    logic [MS_W-1:0]   interval_cfg = REPEAT_INTERVAL_RST;
    logic [TPM_W-1:0]  tpm_cfg = TICKS_PER_MS_RST;
    logic [BTN_W-1:0]  btn_armed = '0;
    logic [TICK_W-1:0] btn_due [BTN_W] = '{default: '0};

    poll_t   poll_queue [$];
    report_t expected_reports [$];
    poll_t   cur_poll;
    report_t want;
    int      polls_accepted = 0;
    int      reports_seen = 0;
    int      poll_gap = 0;
    int      ready_hold = 0;
    int      stuck_cycles = 0;
    int      error_count = 0;
    bit      pressure_done = 1'b0;

    button_autorepeat_scanner #(
        .NUM_BUTTONS(BTN_W),
        .TICK_WIDTH (TICK_W)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rearm           (s_rearm),
        .s_raw_buttons     (s_raw_buttons),
        .s_axis_x          (s_axis_x),
        .s_axis_y          (s_axis_y),
        .s_now_tick        (s_now_tick),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_reported_buttons(m_reported_buttons),
        .m_stick_directions(m_stick_directions),
        .m_stick_x_out     (m_stick_x_out),
        .m_stick_y_out     (m_stick_y_out)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Ticks covered by a span of milliseconds, truncated to the tick width
    function automatic logic [TICK_W-1:0] span_ticks(input logic [MS_W-1:0] ms);
        logic [SPAN_PROD_W-1:0] prod;
        prod = SPAN_PROD_W'(ms) * SPAN_PROD_W'(tpm_cfg);
        return TICK_W'(prod);
    endfunction

    // Advance the button timers for one accepted poll and queue its report, unless it is a rearm
    task automatic predict_poll(input poll_t p);
        report_t r;
        r = '0;
        if (p.rearm) begin
            if (mode_cfg) begin
                for (int i = 0; i < BTN_W; i++) begin
                    btn_armed[i] = p.raw[i];
                    btn_due[i] = p.raw[i] ? p.now + span_ticks(delay_cfg) : '0;
                end
            end
        end else begin
            for (int i = 0; i < BTN_W; i++) begin
                if (!mode_cfg) begin
                    r.buttons[i] = p.raw[i];
                end else if (p.raw[i]) begin
                    if (!btn_armed[i] || p.now >= btn_due[i]) begin
                        r.buttons[i] = 1'b1;
                        btn_due[i] = p.now +
                            span_ticks(btn_armed[i] ? interval_cfg : delay_cfg);
                        btn_armed[i] = 1'b1;
                    end
                end else begin
                    btn_armed[i] = 1'b0;
                    btn_due[i] = '0;
                end
            end
            if (p.ay < AXIS_LOW)
                r.dirs[DIR_UP] = 1'b1;
            else if (p.ay >= AXIS_HIGH)
                r.dirs[DIR_DOWN] = 1'b1;
            if (p.ax < AXIS_LOW)
                r.dirs[DIR_LEFT] = 1'b1;
            else if (p.ax >= AXIS_HIGH)
                r.dirs[DIR_RIGHT] = 1'b1;
            r.x = p.ax;
            r.y = p.ay;
            expected_reports.push_back(r);
        end
    endtask

    // Idle length for either side: mostly none, some short, a few long
    function automatic int pick_gap(input logic no_idle);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [AXIS_W-1:0] pick_axis();
        if ($urandom_range(0, 9) < 3)
            return AXIS_EDGES[$urandom_range(0, 7)];
        return AXIS_W'($urandom());
    endfunction

    function automatic void push_poll(input logic rearm, input logic [BTN_W-1:0] raw,
                                      input logic [AXIS_W-1:0] ax,
                                      input logic [AXIS_W-1:0] ay,
                                      input logic [TICK_W-1:0] now);
        poll_queue.push_back('{rearm, raw, ax, ay, now});
    endfunction

    // Write one register, then wait for the span products to refresh
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_AUTOREPEAT_MODE: mode_cfg = value[0];
            CFG_INITIAL_DELAY:   delay_cfg = value[MS_W-1:0];
            CFG_REPEAT_INTERVAL: interval_cfg = value[MS_W-1:0];
            CFG_TICKS_PER_MS:    tpm_cfg = value[TPM_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(input logic mode, input logic [MS_W-1:0] d,
                              input logic [MS_W-1:0] iv, input logic [TPM_W-1:0] tpm);
        write_reg(CFG_AUTOREPEAT_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_INITIAL_DELAY, CFG_DATA_W'(d));
        write_reg(CFG_REPEAT_INTERVAL, CFG_DATA_W'(iv));
        write_reg(CFG_TICKS_PER_MS, CFG_DATA_W'(tpm));
    endtask

    // Wait until every poll is taken and every report is back, then let rearms finish
    task automatic wait_idle();
        while (poll_queue.size() != 0 || s_valid || expected_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Poll driver: hold the payload until the transfer, then idle or load the next poll
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_poll(cur_poll);
                polls_accepted++;
                poll_gap = pick_gap(polls_accepted[7:6] == 2'b11);
            end
            if (s_valid && !s_ready) begin
                // hold
            end else if (poll_gap > 0) begin
                poll_gap--;
                s_valid <= 1'b0;
            end else if (poll_queue.size() != 0) begin
                cur_poll = poll_queue.pop_front();
                s_valid       <= 1'b1;
                s_rearm       <= cur_poll.rearm;
                s_raw_buttons <= cur_poll.raw;
                s_axis_x      <= cur_poll.ax;
                s_axis_y      <= cur_poll.ay;
                s_now_tick    <= cur_poll.now;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Report monitor: check each transfer against the oldest expectation, pace m_ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                reports_seen++;
                if (expected_reports.size() == 0) begin
                    $error("unexpected report: reported_buttons %h", m_reported_buttons);
                    error_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (m_reported_buttons !== want.buttons) begin
                        $error("reported_buttons: expected %h, got %h",
                               want.buttons, m_reported_buttons);
                        error_count++;
                    end
                    if (m_stick_directions !== want.dirs) begin
                        $error("stick_directions: expected %h, got %h",
                               want.dirs, m_stick_directions);
                        error_count++;
                    end
                    if (m_stick_x_out !== want.x) begin
                        $error("stick_x_out: expected %h, got %h", want.x, m_stick_x_out);
                        error_count++;
                    end
                    if (m_stick_y_out !== want.y) begin
                        $error("stick_y_out: expected %h, got %h", want.y, m_stick_y_out);
                        error_count++;
                    end
                end
            end
            if (ready_hold > 0) begin
                ready_hold--;
                m_ready <= 1'b0;
            end else if (!pressure_done && reports_seen >= 300 && poll_queue.size() > 20) begin
                // long hold-off so the pipeline backs up into the poll side
                pressure_done = 1'b1;
                ready_hold = PRESSURE_HOLD;
                m_ready <= 1'b0;
            end else begin
                ready_hold = pick_gap(reports_seen[7:6] == 2'b01);
                m_ready <= (ready_hold == 0);
            end
        end
    end

    // Watchdog: count cycles with work pending and no transfer on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            !(s_valid || poll_queue.size() != 0 || expected_reports.size() != 0)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        logic              mode;
        logic [MS_W-1:0]   d;
        logic [MS_W-1:0]   iv;
        logic [TPM_W-1:0]  tpm;
        logic [BTN_W-1:0]  held;
        logic [TICK_W-1:0] now_t;
        logic [63:0]       step_max;
        logic [63:0]       rnd64;
        int                r;
        int                b;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Direct reporting at reset defaults: axis thresholds, all buttons, a rearm poll gives no report
        push_poll(1'b0, 12'h000, 8'd0, 8'd255, 48'd1);
        push_poll(1'b0, 12'hFFF, 8'd31, 8'd224, TICK_MAX);
        push_poll(1'b0, 12'hA5A, 8'd32, 8'd223, 48'd0);
        push_poll(1'b1, 12'hFFF, 8'd255, 8'd0, 48'd100);
        push_poll(1'b0, 12'h5A5, 8'd224, 8'd31, 48'd200);
        push_poll(1'b0, 12'h001, 8'd128, 8'd128, 48'd300);
        wait_idle();

        // Autorepeat: 1000-tick delay, 2000-tick repeat
        set_config(1'b1, 16'd1, 16'd2, 20'd1000);
        push_poll(1'b0, 12'h001, 8'd128, 8'd128, 48'd10000);
        push_poll(1'b0, 12'h001, 8'd100, 8'd140, 48'd10500);
        push_poll(1'b0, 12'h001, 8'd128, 8'd128, 48'd11000);
        push_poll(1'b0, 12'h001, 8'd10, 8'd240, 48'd12999);
        push_poll(1'b0, 12'h001, 8'd128, 8'd128, 48'd13000);
        push_poll(1'b0, 12'h000, 8'd128, 8'd128, 48'd13100);
        push_poll(1'b0, 12'h001, 8'd128, 8'd128, 48'd13200);
        push_poll(1'b1, 12'h003, 8'd128, 8'd128, 48'd20000);
        push_poll(1'b0, 12'h003, 8'd128, 8'd128, 48'd20500);
        push_poll(1'b0, 12'h003, 8'd128, 8'd128, 48'd21000);
        // press just before the tick counter wraps so the timer lands on zero
        push_poll(1'b0, 12'h004, 8'd128, 8'd128, TICK_MAX - 48'd999);
        push_poll(1'b0, 12'h004, 8'd128, 8'd128, 48'd5);
        push_poll(1'b0, 12'h004, 8'd128, 8'd128, 48'd6);
        push_poll(1'b1, 12'h000, 8'd128, 8'd128, 48'd7);
        wait_idle();

        // Zero ticks per ms: every held button reports on every poll that is not a rearm
        write_reg(CFG_TICKS_PER_MS, '0);
        push_poll(1'b0, 12'hFFF, 8'd128, 8'd128, 48'd8);
        push_poll(1'b0, 12'hFFF, 8'd128, 8'd128, 48'd8);
        push_poll(1'b1, 12'h00F, 8'd128, 8'd128, 48'd9);
        push_poll(1'b0, 12'h00F, 8'd128, 8'd128, 48'd9);
        wait_idle();

        // Random phases: held-button sequences with advancing time, plus noise and rearms
        held = '0;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    mode = 1'b1; d = MS_W'($urandom_range(0, 20));
                    iv = MS_W'($urandom_range(0, 10)); tpm = TPM_W'($urandom_range(1, 8));
                end
                1: begin
                    mode = 1'b0; d = MS_W'($urandom_range(0, 20));
                    iv = MS_W'($urandom_range(0, 10)); tpm = TPM_W'($urandom_range(1, 8));
                end
                2: begin
                    mode = 1'b1; d = '0; iv = '0; tpm = 20'd1;
                end
                3: begin
                    mode = 1'b1; d = '1; iv = '1; tpm = '1;
                end
                4: begin
                    mode = 1'b1; d = MS_W'($urandom_range(0, 20));
                    iv = MS_W'($urandom_range(0, 10)); tpm = '0;
                end
                5: begin
                    mode = 1'b1; d = MS_W'($urandom_range(0, 20));
                    iv = MS_W'($urandom_range(1, 10)); tpm = TPM_W'($urandom_range(1, 8));
                end
                6: begin
                    mode = 1'b1; d = MS_W'($urandom());
                    iv = MS_W'($urandom()); tpm = TPM_W'($urandom_range(1, 1048575));
                end
                default: begin
                    mode = 1'b1; d = 16'd1; iv = 16'd1; tpm = 20'd1;
                end
            endcase
            set_config(mode, d, iv, tpm);

            step_max = ((d > iv ? 64'(d) : 64'(iv)) * 64'(tpm)) / 4 + 2;
            rnd64 = {$urandom(), $urandom()};
            // even phases start near the top so the tick counter wraps
            if (phase[0])
                now_t = TICK_W'(rnd64);
            else
                now_t = TICK_MAX - TICK_W'(rnd64 % (step_max * 40 + 1));

            for (int k = 0; k < PHASE_POLLS; k++) begin
                r = $urandom_range(0, 99);
                if ($urandom_range(0, 3) == 0) begin
                    b = $urandom_range(0, BTN_W - 1);
                    held[b] = ~held[b];
                end
                if ($urandom_range(0, 19) == 0)
                    held = BTN_W'($urandom());
                rnd64 = {$urandom(), $urandom()};
                now_t = now_t + TICK_W'(rnd64 % (step_max + 1));
                if (r < 6)
                    push_poll(1'b1, held, pick_axis(), pick_axis(), now_t);
                else if (r < 14)
                    push_poll(1'b0, BTN_W'($urandom()), pick_axis(), pick_axis(),
                              TICK_W'({$urandom(), $urandom()}));
                else
                    push_poll(1'b0, held, pick_axis(), pick_axis(), now_t);
            end
            wait_idle();
        end

        if (expected_reports.size() != 0) begin
            $error("%0d reports never arrived", expected_reports.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
